// ===== sv/phone_number_token_scanner_core_defines.svh =====
// Assertion macros used by the phone number token scanner top level.
`ifndef PHONE_NUMBER_TOKEN_SCANNER_CORE_DEFINES_SVH
`define PHONE_NUMBER_TOKEN_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define PNTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pnts assertion failed");

// Next-cycle implication, disabled while reset is active.
`define PNTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pnts assertion failed");

`endif

// ===== sv/pnts_pkg.sv =====
// Types, constants and character classes for the phone number token scanner.
`timescale 1ns / 1ps
package pnts_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned HIST_LEN        = 16;
  localparam int unsigned TOKEN_LEN       = 15;
  localparam int unsigned DIGIT_COUNT     = 9;

  localparam logic [7:0] CHAR_EIGHT = 8'h38;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [3:0] DIGIT_POS [DIGIT_COUNT] = '{
    4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd10, 4'd11, 4'd13, 4'd14
  };

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } pnts_in_t;

  typedef struct packed {
    logic [29:0] phone_digits;
    logic [6:0]  stored_count;
    logic        not_stored;
  } pnts_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SEARCH,
    ST_RESULT
  } pnts_state_e;

  typedef struct packed {
    logic accept;
    logic conv_step;
    logic search_start;
    logic search_step;
    logic commit;
  } pnts_cmd_t;

  typedef struct packed {
    logic match;
    logic conv_last;
    logic hit;
    logic done;
    logic out_busy;
  } pnts_status_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CHAR_SPACE, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CHAR_ZERO:CHAR_NINE]};
  endfunction

  function automatic logic is_end_mark(input logic [7:0] c);
    return is_space(c) || (c inside {CHAR_COMMA, CHAR_DOT, CHAR_SEMI});
  endfunction

endpackage

// ===== sv/phone_number_token_scanner_core.sv =====
// Top level of the phone number token scanner: controller, datapath and checks.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_ready_o   in_data_i  (text_byte, last_byte)
//   result   out        out_valid_o / out_ready_i out_data_o (phone_digits, stored_count,
//                                                             not_stored)
//
// A byte that completes no token leaves the controller idle, so plain text streams at one byte
// a cycle. A byte that completes a token is followed by conversion of its nine digits, a scan
// of the stored numbers through the single table read port and, for a new number, a commit.
// The commit waits while the previous result is still held in the output register.
// Reset clears the history, the fill count and the handshake state; table contents are left
// as they are, since only entries below the fill count are ever read.
`timescale 1ns / 1ps
`include "phone_number_token_scanner_core_defines.svh"
module phone_number_token_scanner_core
  import pnts_pkg::*;
#(
  parameter int unsigned TableDepth = TABLE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pnts_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pnts_out_t out_data_o
);

  pnts_cmd_t    cmd;
  pnts_status_t status;

  pnts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  pnts_datapath #(
    .TableDepth (TableDepth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // A result is committed only when the output register is free or being emptied.
  `PNTS_ASSERT_SAME(a_commit_slot_free, clk_i, rst_ni, cmd.commit, !out_valid_o || out_ready_i)

  // A transaction that completes no token leaves the block ready in the next cycle.
  `PNTS_ASSERT_NEXT(a_plain_byte_ready, clk_i, rst_ni, in_valid_i && in_ready_o && !status.match, in_ready_o)

  // A number found in the table is never reported.
  `PNTS_ASSERT_SAME(a_no_commit_on_hit, clk_i, rst_ni, cmd.commit, !status.hit)

endmodule

// ===== sv/pnts_ctrl.sv =====
// Controller state machine that sequences matching, digit conversion, table search and commit.
`timescale 1ns / 1ps
module pnts_ctrl
  import pnts_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         out_ready_i,
  input  pnts_status_t status_i,
  output logic         in_ready_o,
  output pnts_cmd_t    cmd_o
);

  pnts_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.match) begin
          state_d = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd_o.conv_step = 1'b1;
        if (status_i.conv_last) begin
          cmd_o.search_start = 1'b1;
          state_d            = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (status_i.hit) begin
          state_d = ST_IDLE;
        end else if (status_i.done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!status_i.out_busy || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/pnts_datapath.sv =====
// Datapath: byte history, token matcher, digit converter, number table and result register.
`timescale 1ns / 1ps
module pnts_datapath
  import pnts_pkg::*;
#(
  parameter int unsigned TableDepth = TABLE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pnts_in_t     in_data_i,
  input  logic         out_ready_i,
  input  pnts_cmd_t    cmd_i,
  output pnts_status_t status_o,
  output logic         out_valid_o,
  output pnts_out_t    out_data_o
);

  localparam int unsigned FillW = $clog2(TableDepth + 1);
  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  logic [7:0]       hist_q [HIST_LEN];
  logic [4:0]       since_q;
  logic [3:0]       digits_q [DIGIT_COUNT];
  logic [3:0]       conv_cnt_q;
  logic [29:0]      value_q;
  logic [29:0]      mem_q [TableDepth];
  logic [29:0]      rdata_q;
  logic             cmp_vld_q;
  logic [FillW-1:0] rd_idx_q;
  logic [FillW-1:0] fill_q;
  logic             out_valid_q;
  pnts_out_t        out_q;

  logic [7:0] tok [TOKEN_LEN];
  logic       delim_case;
  logic       last_case;
  logic       lead_ok;
  logic       shape_ok;
  logic       full;
  logic       rd_more;

  assign delim_case = is_end_mark(in_data_i.text_byte) && (since_q >= 5'(TOKEN_LEN));
  assign last_case  = !delim_case && in_data_i.last_byte && (since_q >= 5'(TOKEN_LEN - 1));

  always_comb begin
    for (int k = 0; k < TOKEN_LEN; k++) begin
      if (delim_case) begin
        tok[k] = hist_q[TOKEN_LEN - 1 - k];
      end else if (k == TOKEN_LEN - 1) begin
        tok[k] = in_data_i.text_byte;
      end else begin
        tok[k] = hist_q[TOKEN_LEN - 2 - k];
      end
    end
    if (delim_case) begin
      lead_ok = (since_q == 5'(TOKEN_LEN)) || is_space(hist_q[TOKEN_LEN]);
    end else begin
      lead_ok = (since_q == 5'(TOKEN_LEN - 1)) || is_space(hist_q[TOKEN_LEN - 1]);
    end
    shape_ok = (tok[0] == CHAR_EIGHT) && is_space(tok[1]) && (tok[2] == CHAR_NINE) &&
               is_space(tok[5]) && (tok[9] == CHAR_DASH) && (tok[12] == CHAR_DASH);
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      shape_ok = shape_ok && is_digit(tok[DIGIT_POS[k]]);
    end
  end

  assign full    = (fill_q == FillW'(TableDepth));
  assign rd_more = (rd_idx_q < fill_q);

  assign status_o.match     = (delim_case || last_case) && lead_ok && shape_ok;
  assign status_o.conv_last = (conv_cnt_q == 4'(DIGIT_COUNT - 1));
  assign status_o.hit       = cmp_vld_q && (rdata_q == value_q);
  assign status_o.done      = !cmp_vld_q && !rd_more;
  assign status_o.out_busy  = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HIST_LEN; k++) begin
        hist_q[k] <= '0;
      end
      since_q <= '0;
    end else if (cmd_i.accept) begin
      if (in_data_i.last_byte) begin
        for (int k = 0; k < HIST_LEN; k++) begin
          hist_q[k] <= '0;
        end
        since_q <= '0;
      end else begin
        hist_q[0] <= in_data_i.text_byte;
        for (int k = 1; k < HIST_LEN; k++) begin
          hist_q[k] <= hist_q[k-1];
        end
        if (since_q < 5'(HIST_LEN)) begin
          since_q <= since_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && status_o.match) begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        digits_q[k] <= tok[DIGIT_POS[k]][3:0];
      end
      value_q    <= '0;
      conv_cnt_q <= '0;
    end else if (cmd_i.conv_step) begin
      value_q <= (value_q << 3) + (value_q << 1) + 30'(digits_q[0]);
      for (int k = 0; k < DIGIT_COUNT - 1; k++) begin
        digits_q[k] <= digits_q[k+1];
      end
      digits_q[DIGIT_COUNT-1] <= '0;
      conv_cnt_q <= conv_cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search_step && rd_more) begin
      rdata_q <= mem_q[rd_idx_q[AddrW-1:0]];
    end
    if (cmd_i.commit && !full) begin
      mem_q[fill_q[AddrW-1:0]] <= value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else if (cmd_i.search_start) begin
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.search_step && rd_more;
      if (cmd_i.search_step && rd_more) begin
        rd_idx_q <= rd_idx_q + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (!full) begin
          fill_q <= fill_q + FillW'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.phone_digits <= value_q;
      out_q.stored_count <= full ? 7'(fill_q) : 7'(fill_q + FillW'(1));
      out_q.not_stored   <= full;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
